>>> rtl/core/npps_pkg.sv
`timescale 1ns / 1ps

package npps_pkg;

   localparam int ID_W   = 16;
   localparam int RUN_W  = 16;
   localparam int PRIO_W = 8;
   localparam int CTR_W  = 32;

   // one waiting job as held by a queue cell
   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [RUN_W-1:0]  run;
      logic [PRIO_W-1:0] prio;
   } entry_type;

   // per-tick queue operations broadcast to every cell
   typedef struct packed {
      logic insert;
      logic dispatch;
   } ctrl_type;

endpackage

>>> rtl/core/npps_cell.sv
`timescale 1ns / 1ps

module npps_cell (
   input  logic               clock,
   input  npps_pkg::ctrl_type  ctrl,
   input  logic               occupied,
   input  npps_pkg::entry_type new_entry,
   input  npps_pkg::entry_type prev_entry,
   input  logic               prev_lt,
   input  npps_pkg::entry_type next_ins,
   output npps_pkg::entry_type cur_entry,
   output logic               lt,
   output logic               is_pos,
   output npps_pkg::entry_type ins_entry
);
   import npps_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   assign cur_entry = entry_ff;

   // waiting job here is served before the arriving one
   assign lt     = occupied && (entry_ff.prio < new_entry.prio);
   assign is_pos = !lt && prev_lt;

   // contents after the arrival is placed
   always_comb begin
      if (!ctrl.insert || lt) begin
         ins_entry = entry_ff;
      end else if (is_pos) begin
         ins_entry = new_entry;
      end else begin
         ins_entry = prev_entry;
      end
   end

   // head removal pulls from the neighbor behind
   assign entry_in = ctrl.dispatch ? next_ins : ins_entry;

   always_ff @(posedge clock) begin
      if (ctrl.insert || ctrl.dispatch) begin
         entry_ff <= entry_in;
      end
   end

endmodule

>>> rtl/core/nonpreemptive_priority_scheduler.sv
`timescale 1ns / 1ps
// channel  direction  handshake             payload
// req      in         req_valid/req_stall   arrival_valid, job_id, job_run_time, job_priority
// rsp      out        rsp_valid/rsp_stall   finished_*, processor_busy, queue_count, ...
//
// one tick word per clock while req_stall is low; the word is applied to the cell chain in the cycle it is taken
// and its status word appears in the output register on the next cycle
// req_stall is high while the output register holds a word that rsp_stall is holding back
// synchronous active-high reset empties the queue, idles the processor, clears counters
// queue cells hold no reset; only the first queue_count cells hold valid entries

module nonpreemptive_priority_scheduler #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_arrival_valid,
   input  logic [npps_pkg::ID_W-1:0]             req_job_id,
   input  logic [npps_pkg::RUN_W-1:0]            req_job_run_time,
   input  logic [npps_pkg::PRIO_W-1:0]           req_job_priority,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_finished_valid,
   output logic [npps_pkg::ID_W-1:0]             rsp_finished_id,
   output logic                                  rsp_processor_busy,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]      rsp_queue_count,
   output logic                                  rsp_arrival_dropped,
   output logic [npps_pkg::CTR_W-1:0]            rsp_insert_visits_total,
   output logic [npps_pkg::CTR_W-1:0]            rsp_dispatch_total
);
   import npps_pkg::*;

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int IDX_W = $clog2(QUEUE_DEPTH);

   logic [CNT_W-1:0] count_ff, count_in;
   logic [ID_W-1:0]  running_id_ff, running_id_in;
   logic [RUN_W-1:0] remaining_ff, remaining_in;
   logic             busy_ff, busy_in;
   logic [CTR_W-1:0] visits_ff, visits_in;
   logic [CTR_W-1:0] dispatches_ff, dispatches_in;

   logic             rsp_valid_ff;
   logic             fin_valid_ff;
   logic [ID_W-1:0]  fin_id_ff;
   logic             dropped_ff;

   logic             fire;
   ctrl_type         ctrl;
   entry_type        new_entry;
   logic             full;
   logic             do_insert;
   logic [RUN_W-1:0] rem_dec;
   logic             finish;
   logic             busy_mid;
   logic [CNT_W-1:0] count_mid;
   logic             do_dispatch;
   logic [IDX_W-1:0] pos;
   logic [CTR_W:0]   visit_sum;

   entry_type               cur_entry [QUEUE_DEPTH];
   entry_type               ins_entry [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0]  lt;
   logic [QUEUE_DEPTH-1:0]  is_pos;

   // handshake
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign fire      = req_valid && !req_stall;

   // arriving job, zero run time counts as one
   always_comb begin
      new_entry.id   = req_job_id;
      new_entry.run  = (req_job_run_time == '0) ? RUN_W'(1) : req_job_run_time;
      new_entry.prio = req_job_priority;
   end

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign do_insert = req_arrival_valid && !full;

   // countdown of the running job
   assign rem_dec   = remaining_ff - RUN_W'(1);
   assign finish    = busy_ff && (rem_dec == '0);
   assign busy_mid  = busy_ff && !finish;
   assign count_mid = count_ff + CNT_W'(do_insert);
   assign do_dispatch = !busy_mid && (count_mid != '0);

   // queue operations for this tick
   always_comb begin
      ctrl.insert   = fire && do_insert;
      ctrl.dispatch = fire && do_dispatch;
   end

   // sorted queue, head at cell 0
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      npps_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .occupied   (count_ff > CNT_W'(i)),
         .new_entry  (new_entry),
         .prev_entry ((i == 0) ? new_entry : cur_entry[(i == 0) ? 0 : i - 1]),
         .prev_lt    ((i == 0) ? 1'b1 : lt[(i == 0) ? 0 : i - 1]),
         .next_ins   ((i == QUEUE_DEPTH - 1) ? ins_entry[i]
                                             : ins_entry[(i == QUEUE_DEPTH - 1) ? i : i + 1]),
         .cur_entry  (cur_entry[i]),
         .lt         (lt[i]),
         .is_pos     (is_pos[i]),
         .ins_entry  (ins_entry[i])
      );
   end

   // insertion slot index from the one-hot position flags
   always_comb begin
      pos = '0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (is_pos[i]) begin
            pos = pos | IDX_W'(i);
         end
      end
   end

   assign visit_sum = {1'b0, visits_ff} + {{(CTR_W + 1 - IDX_W){1'b0}}, pos} + (CTR_W + 1)'(1);

   // next state of the processor and counters
   always_comb begin
      count_in      = count_mid - CNT_W'(do_dispatch);
      busy_in       = busy_mid || do_dispatch;
      running_id_in = do_dispatch ? ins_entry[0].id : running_id_ff;
      if (do_dispatch) begin
         remaining_in = ins_entry[0].run;
      end else if (busy_ff) begin
         remaining_in = rem_dec;
      end else begin
         remaining_in = remaining_ff;
      end
      if (!do_insert) begin
         visits_in = visits_ff;
      end else if (visit_sum[CTR_W]) begin
         visits_in = '1;
      end else begin
         visits_in = visit_sum[CTR_W-1:0];
      end
      if (do_dispatch && (dispatches_ff != '1)) begin
         dispatches_in = dispatches_ff + CTR_W'(1);
      end else begin
         dispatches_in = dispatches_ff;
      end
   end

   // state and output word registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         running_id_ff <= '0;
         remaining_ff  <= '0;
         busy_ff       <= 1'b0;
         visits_ff     <= '0;
         dispatches_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (fire) begin
            count_ff      <= count_in;
            running_id_ff <= running_id_in;
            remaining_ff  <= remaining_in;
            busy_ff       <= busy_in;
            visits_ff     <= visits_in;
            dispatches_ff <= dispatches_in;
            rsp_valid_ff  <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff  <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         fin_valid_ff <= finish;
         fin_id_ff    <= finish ? running_id_ff : '0;
         dropped_ff   <= req_arrival_valid && full;
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_finished_valid      = fin_valid_ff;
   assign rsp_finished_id         = fin_id_ff;
   assign rsp_processor_busy      = busy_ff;
   assign rsp_queue_count         = count_ff;
   assign rsp_arrival_dropped     = dropped_ff;
   assign rsp_insert_visits_total = visits_ff;
   assign rsp_dispatch_total      = dispatches_ff;

endmodule
